### rtl/mffa_pkg.sv
// Shared types, constants and codes for the multicore first-fit arena allocator.
package mffa_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int MAX_CORES   = 64;
    localparam int SEAL_BITS   = 8;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CFG_IDX_W   = 2;

    localparam logic [2:0] REQ_ALLOC   = 3'd0;
    localparam logic [2:0] REQ_DEALLOC = 3'd1;
    localparam logic [2:0] REQ_HWM     = 3'd2;
    localparam logic [2:0] REQ_SEAL    = 3'd3;
    localparam logic [2:0] REQ_UNSEAL  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd3;

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_NOSPACE   = 4'd1,
        ST_SEALED    = 4'd2,
        ST_BADREQ    = 4'd3,
        ST_UNKNOWN   = 4'd4,
        ST_FULL      = 4'd5,
        ST_SEALOVF   = 4'd6,
        ST_NOTSEALED = 4'd7,
        ST_IDEXH     = 4'd8
    } status_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [63:0] core_mask;
        logic [31:0] request_size;
        logic [4:0]  align_log2;
        logic [31:0] free_id;
    } req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [31:0] granted_id;
        logic [31:0] result_address;
    } rsp_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEARCH_INIT,
        OP_PASS_INIT,
        OP_SCAN_FIND,
        OP_SCAN_MERGE,
        OP_ADVANCE,
        OP_COMMIT,
        OP_IDX_CLEAR,
        OP_DEALLOC_STEP,
        OP_HWM_STEP,
        OP_SEAL_APPLY,
        OP_FINISH
    } op_t;

    typedef struct packed {
        op_t     op;
        status_t st;
    } cmd_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic       alloc_bad;
        logic       core_sealed;
        logic       grid_bad;
        logic       seal_ovf;
        logic       not_sealed;
        logic       fid_zero;
        logic       no_space;
        logic       pass_done;
        logic       id_exh;
        logic       table_full;
        logic       dealloc_hit;
        logic       idx_last;
        logic       out_free;
    } stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_PASS,
        S_FIND,
        S_MERGE,
        S_PASS_END,
        S_COMMIT,
        S_DEALLOC,
        S_HWM,
        S_OUT
    } state_t;

endpackage

### rtl/mffa_datapath.sv
// Datapath of the allocator: configuration, entry table, seal counts, search and result register.
module mffa_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mffa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    input  mffa_pkg::req_t                 req_word,
    input  mffa_pkg::cmd_t                 cmd,
    output mffa_pkg::stat_t                stat,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output mffa_pkg::rsp_t                 rsp_word
);

    localparam int NE = mffa_pkg::MAX_ENTRIES;
    localparam int NC = mffa_pkg::MAX_CORES;
    localparam int IW = mffa_pkg::IDX_W;
    localparam logic [mffa_pkg::SEAL_BITS-1:0] SEAL_MAX = '1;
    localparam logic [mffa_pkg::SEAL_BITS-1:0] SEAL_ONE = mffa_pkg::SEAL_BITS'(1);

    logic [31:0] base_reg, limit_reg;
    logic [3:0]  cols_reg, rows_reg;
    logic [31:0] next_id_reg;
    logic [NE-1:0] ent_valid_reg;
    logic [NC-1:0] best_vld_reg;
    logic [mffa_pkg::SEAL_BITS-1:0] seal_reg [NC];
    logic          rsp_valid_reg;
    logic [IW-1:0] idx_reg, idx_next;

    mffa_pkg::req_t req_reg;
    logic [33:0] cand_reg, cand_next;
    logic [33:0] next_reg, next_next;
    logic [32:0] hw_reg, hw_next;
    logic [31:0] gid_reg;
    logic [31:0] ent_id_reg    [NE];
    logic [31:0] ent_begin_reg [NE];
    logic [32:0] ent_end_reg   [NE];
    logic [63:0] ent_cores_reg [NE];
    logic [31:0] best_beg_reg  [NC];
    logic [IW-1:0] best_idx_reg [NC];
    mffa_pkg::rsp_t rsp_reg;

    logic [33:0] align_m, size34, lim34, cand_end;
    logic [31:0] cur_id, cur_begin;
    logic [32:0] cur_end;
    logic [63:0] cur_cores;
    logic        cur_valid, overlap, chosen;
    logic [33:0] cur_end_al, base_al;
    logic [7:0]  ncores;
    logic [63:0] grid_mask;
    logic        sealed_any, ovf_any, zero_any;
    logic [IW-1:0] free_slot;
    logic          free_found;
    logic [NC-1:0] find_upd;
    logic          rsp_take;

    assign align_m   = (34'd1 << req_reg.align_log2) - 34'd1;
    assign size34    = {2'b00, req_reg.request_size};
    assign lim34     = {2'b00, limit_reg};
    assign cand_end  = cand_reg + size34;
    assign cur_valid = ent_valid_reg[idx_reg];
    assign cur_id    = ent_id_reg[idx_reg];
    assign cur_begin = ent_begin_reg[idx_reg];
    assign cur_end   = ent_end_reg[idx_reg];
    assign cur_cores = ent_cores_reg[idx_reg];
    assign overlap   = cur_valid && (cand_reg < {1'b0, cur_end})
                       && (cand_end > {2'b00, cur_begin});
    assign cur_end_al = ({1'b0, cur_end} + align_m) & ~align_m;
    assign base_al    = ({2'b00, base_reg} + align_m) & ~align_m;

    assign ncores    = {4'd0, cols_reg} * {4'd0, rows_reg};
    assign grid_mask = (ncores >= 8'(NC)) ? '1 : ((64'd1 << ncores[5:0]) - 64'd1);

    always_comb
    begin
        chosen     = 1'b0;
        sealed_any = 1'b0;
        ovf_any    = 1'b0;
        zero_any   = 1'b0;
        for (int c = 0; c < NC; c++)
        begin
            if (best_vld_reg[c] && (best_idx_reg[c] == idx_reg))
                chosen = 1'b1;
            if (req_reg.core_mask[c])
            begin
                if (seal_reg[c] != '0)
                    sealed_any = 1'b1;
                if (seal_reg[c] == SEAL_MAX)
                    ovf_any = 1'b1;
                if (seal_reg[c] == '0)
                    zero_any = 1'b1;
            end
            find_upd[c] = overlap && req_reg.core_mask[c] && cur_cores[c]
                          && (!best_vld_reg[c] || (cur_begin < best_beg_reg[c]));
        end
    end

    // Lowest free table slot for a new allocation.
    always_comb
    begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int e = NE - 1; e >= 0; e--)
        begin
            if (!ent_valid_reg[e])
            begin
                free_slot  = IW'(e);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.req_type    = req_reg.req_type;
        stat.alloc_bad   = (req_reg.core_mask == '0) || (req_reg.request_size == '0)
                           || ((req_reg.core_mask & ~grid_mask) != '0);
        stat.core_sealed = sealed_any;
        stat.grid_bad    = (req_reg.core_mask & ~grid_mask) != '0;
        stat.seal_ovf    = ovf_any;
        stat.not_sealed  = zero_any;
        stat.fid_zero    = req_reg.free_id == '0;
        stat.no_space    = (cand_reg > lim34) || (size34 > (lim34 - cand_reg));
        stat.pass_done   = next_reg == cand_reg;
        stat.id_exh      = next_id_reg == '0;
        stat.table_full  = !free_found;
        stat.dealloc_hit = cur_valid && (cur_id == req_reg.free_id);
        stat.idx_last    = idx_reg == IW'(NE - 1);
        stat.out_free    = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_take = rsp_valid_reg && !rsp_stall;

    always_comb
    begin
        idx_next  = idx_reg;
        cand_next = cand_reg;
        next_next = next_reg;
        hw_next   = hw_reg;
        unique case (cmd.op) inside
            mffa_pkg::OP_SEARCH_INIT: cand_next = base_al;
            mffa_pkg::OP_PASS_INIT:
            begin
                idx_next  = '0;
                next_next = cand_reg;
            end
            mffa_pkg::OP_SCAN_FIND,
            mffa_pkg::OP_DEALLOC_STEP:
                idx_next = stat.idx_last ? '0 : idx_reg + IW'(1);
            mffa_pkg::OP_SCAN_MERGE:
            begin
                idx_next = stat.idx_last ? '0 : idx_reg + IW'(1);
                if (chosen && (cur_end_al > next_reg))
                    next_next = cur_end_al;
            end
            mffa_pkg::OP_ADVANCE: cand_next = next_reg;
            mffa_pkg::OP_IDX_CLEAR:
            begin
                idx_next = '0;
                hw_next  = {1'b0, base_reg};
            end
            mffa_pkg::OP_HWM_STEP:
            begin
                idx_next = stat.idx_last ? '0 : idx_reg + IW'(1);
                if (cur_valid && ((cur_cores & req_reg.core_mask) != '0) && (cur_end > hw_reg))
                    hw_next = cur_end;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            limit_reg     <= '0;
            cols_reg      <= 4'd8;
            rows_reg      <= 4'd8;
            next_id_reg   <= 32'd1;
            ent_valid_reg <= '0;
            best_vld_reg  <= '0;
            rsp_valid_reg <= 1'b0;
            idx_reg       <= '0;
            for (int c = 0; c < NC; c++)
                seal_reg[c] <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mffa_pkg::CFG_BASE:  base_reg  <= cfg_data;
                    mffa_pkg::CFG_LIMIT: limit_reg <= cfg_data;
                    mffa_pkg::CFG_COLS:  cols_reg  <= cfg_data[3:0];
                    mffa_pkg::CFG_ROWS:  rows_reg  <= cfg_data[3:0];
                    default: ;
                endcase
            end
            if (cmd.op == mffa_pkg::OP_PASS_INIT)
                best_vld_reg <= '0;
            if (cmd.op == mffa_pkg::OP_SCAN_FIND)
                best_vld_reg <= best_vld_reg | find_upd;
            if (cmd.op == mffa_pkg::OP_COMMIT)
            begin
                ent_valid_reg[free_slot] <= 1'b1;
                next_id_reg <= next_id_reg + 32'd1;
            end
            if ((cmd.op == mffa_pkg::OP_DEALLOC_STEP) && stat.dealloc_hit)
                ent_valid_reg[idx_reg] <= 1'b0;
            if (cmd.op == mffa_pkg::OP_SEAL_APPLY)
            begin
                for (int c = 0; c < NC; c++)
                begin
                    if (req_reg.core_mask[c])
                    begin
                        if (req_reg.req_type == mffa_pkg::REQ_SEAL)
                            seal_reg[c] <= seal_reg[c] + SEAL_ONE;
                        else
                            seal_reg[c] <= seal_reg[c] - SEAL_ONE;
                    end
                end
            end
            if (cmd.op == mffa_pkg::OP_FINISH)
                rsp_valid_reg <= 1'b1;
            else if (rsp_take)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
        next_reg <= next_next;
        hw_reg   <= hw_next;
        if (cmd.op == mffa_pkg::OP_LOAD)
            req_reg <= req_word;
        if (cmd.op == mffa_pkg::OP_SCAN_FIND)
        begin
            for (int c = 0; c < NC; c++)
            begin
                if (find_upd[c])
                begin
                    best_beg_reg[c] <= cur_begin;
                    best_idx_reg[c] <= idx_reg;
                end
            end
        end
        if (cmd.op == mffa_pkg::OP_COMMIT)
        begin
            ent_id_reg[free_slot]    <= next_id_reg;
            ent_begin_reg[free_slot] <= cand_reg[31:0];
            ent_end_reg[free_slot]   <= cand_end[32:0];
            ent_cores_reg[free_slot] <= req_reg.core_mask;
            gid_reg <= next_id_reg;
        end
        if (cmd.op == mffa_pkg::OP_FINISH)
        begin
            rsp_reg.status <= cmd.st;
            if ((req_reg.req_type == mffa_pkg::REQ_ALLOC) && (cmd.st == mffa_pkg::ST_OK))
            begin
                rsp_reg.granted_id     <= gid_reg;
                rsp_reg.result_address <= cand_reg[31:0];
            end
            else if (req_reg.req_type == mffa_pkg::REQ_HWM)
            begin
                rsp_reg.granted_id     <= '0;
                rsp_reg.result_address <= hw_reg[31:0];
            end
            else
            begin
                rsp_reg.granted_id     <= '0;
                rsp_reg.result_address <= '0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_reg;

endmodule

### rtl/mffa_ctrl.sv
// Controller state machine that sequences each request through the datapath.
module mffa_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  mffa_pkg::stat_t stat,
    output mffa_pkg::cmd_t  cmd
);

    mffa_pkg::state_t  state_reg, state_next;
    mffa_pkg::status_t st_reg, st_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mffa_pkg::S_IDLE;
            st_reg    <= mffa_pkg::ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            st_reg    <= st_next;
        end
    end

    assign req_stall = state_reg != mffa_pkg::S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        st_next    = st_reg;
        cmd.op     = mffa_pkg::OP_NONE;
        cmd.st     = st_reg;
        unique case (state_reg)
            mffa_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = mffa_pkg::OP_LOAD;
                    state_next = mffa_pkg::S_DECODE;
                end
            end
            mffa_pkg::S_DECODE:
            begin
                st_next    = mffa_pkg::ST_OK;
                state_next = mffa_pkg::S_OUT;
                unique case (stat.req_type) inside
                    mffa_pkg::REQ_ALLOC:
                    begin
                        if (stat.alloc_bad)
                            st_next = mffa_pkg::ST_BADREQ;
                        else if (stat.core_sealed)
                            st_next = mffa_pkg::ST_SEALED;
                        else
                        begin
                            cmd.op     = mffa_pkg::OP_SEARCH_INIT;
                            state_next = mffa_pkg::S_PASS;
                        end
                    end
                    mffa_pkg::REQ_DEALLOC:
                    begin
                        if (!stat.fid_zero)
                        begin
                            cmd.op     = mffa_pkg::OP_IDX_CLEAR;
                            state_next = mffa_pkg::S_DEALLOC;
                        end
                    end
                    mffa_pkg::REQ_HWM:
                    begin
                        cmd.op     = mffa_pkg::OP_IDX_CLEAR;
                        state_next = mffa_pkg::S_HWM;
                    end
                    mffa_pkg::REQ_SEAL,
                    mffa_pkg::REQ_UNSEAL:
                    begin
                        if (stat.grid_bad)
                            st_next = mffa_pkg::ST_BADREQ;
                        else if ((stat.req_type == mffa_pkg::REQ_SEAL) && stat.seal_ovf)
                            st_next = mffa_pkg::ST_SEALOVF;
                        else if ((stat.req_type == mffa_pkg::REQ_UNSEAL) && stat.not_sealed)
                            st_next = mffa_pkg::ST_NOTSEALED;
                        else
                            cmd.op = mffa_pkg::OP_SEAL_APPLY;
                    end
                    default: st_next = mffa_pkg::ST_BADREQ;
                endcase
            end
            mffa_pkg::S_PASS:
            begin
                if (stat.no_space)
                begin
                    st_next    = mffa_pkg::ST_NOSPACE;
                    state_next = mffa_pkg::S_OUT;
                end
                else
                begin
                    cmd.op     = mffa_pkg::OP_PASS_INIT;
                    state_next = mffa_pkg::S_FIND;
                end
            end
            mffa_pkg::S_FIND:
            begin
                cmd.op = mffa_pkg::OP_SCAN_FIND;
                if (stat.idx_last)
                    state_next = mffa_pkg::S_MERGE;
            end
            mffa_pkg::S_MERGE:
            begin
                cmd.op = mffa_pkg::OP_SCAN_MERGE;
                if (stat.idx_last)
                    state_next = mffa_pkg::S_PASS_END;
            end
            mffa_pkg::S_PASS_END:
            begin
                if (stat.pass_done)
                    state_next = mffa_pkg::S_COMMIT;
                else
                begin
                    cmd.op     = mffa_pkg::OP_ADVANCE;
                    state_next = mffa_pkg::S_PASS;
                end
            end
            mffa_pkg::S_COMMIT:
            begin
                state_next = mffa_pkg::S_OUT;
                if (stat.id_exh)
                    st_next = mffa_pkg::ST_IDEXH;
                else if (stat.table_full)
                    st_next = mffa_pkg::ST_FULL;
                else
                begin
                    st_next = mffa_pkg::ST_OK;
                    cmd.op  = mffa_pkg::OP_COMMIT;
                end
            end
            mffa_pkg::S_DEALLOC:
            begin
                cmd.op = mffa_pkg::OP_DEALLOC_STEP;
                if (stat.dealloc_hit)
                begin
                    st_next    = mffa_pkg::ST_OK;
                    state_next = mffa_pkg::S_OUT;
                end
                else if (stat.idx_last)
                begin
                    st_next    = mffa_pkg::ST_UNKNOWN;
                    state_next = mffa_pkg::S_OUT;
                end
            end
            mffa_pkg::S_HWM:
            begin
                cmd.op = mffa_pkg::OP_HWM_STEP;
                if (stat.idx_last)
                begin
                    st_next    = mffa_pkg::ST_OK;
                    state_next = mffa_pkg::S_OUT;
                end
            end
            mffa_pkg::S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = mffa_pkg::OP_FINISH;
                    state_next = mffa_pkg::S_IDLE;
                end
            end
            default: state_next = mffa_pkg::S_IDLE;
        endcase
    end

endmodule

### rtl/multicore_first_fit_arena_allocator.sv
// Top level of the multicore first-fit arena allocator.
//
// Requests arrive as one word on the req channel (valid/stall) and each gives exactly one
// response word on the rsp channel. The block works on one request at a time: req_stall is
// high from the cycle after a word is taken until its response has been loaded into the
// output register. A response may wait there under rsp_stall while the next request is
// already being taken and worked on; a finished result only holds in the controller while
// the earlier one is still not taken.
// Seal, unseal, a free of id zero and the early allocate errors skip the table; a
// high-water query walks the whole 16-entry table and a deallocate walks it up to the
// matching entry or its end, one entry per cycle. An allocate runs search passes until
// the candidate stays put or no space is left: each pass walks the table twice, once to
// pick the lowest overlapping region per named core and once to fold the aligned ends of
// the picked regions into the next candidate, so an empty arena needs only one pass.
// Configuration (base, limit, grid columns, grid rows) is written through cfg_we, cfg_index
// and cfg_data; the user must do so only while the block is idle, which it does not enforce.
// Reset clears the allocation table valid bits, the seal counts, the id counter (to one)
// and both handshakes; it needs no clearing pass.
module multicore_first_fit_arena_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  mffa_pkg::req_t                 req_word,
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output mffa_pkg::rsp_t                 rsp_word,
    input  logic                           cfg_we,
    input  logic [mffa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    mffa_pkg::cmd_t  cmd;
    mffa_pkg::stat_t stat;

    // The controller holds the state and status registers; the datapath holds the rest.
    mffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    mffa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_word  (req_word),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word)
    );

`ifndef SYNTHESIS
    // A taken request always keeps the input stalled on the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("input not stalled after accepting a request");

    // A granted id only comes with a successful status.
    a_gid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_word.granted_id != '0)) |-> (rsp_word.status == mffa_pkg::ST_OK))
        else $error("granted id with error status");

    // The response register is loaded only when it is free.
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> $stable(rsp_word))
        else $error("pending response overwritten");
`endif

endmodule

### tb/testbench.sv
// Self-checking testbench for the multicore first-fit arena allocator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           req_valid = 1'b0;
    logic                           req_stall;
    mffa_pkg::req_t                 req_word = '0;
    logic                           rsp_valid;
    logic                           rsp_stall = 1'b0;
    mffa_pkg::rsp_t                 rsp_word;
    logic                           cfg_we = 1'b0;
    logic [mffa_pkg::CFG_IDX_W-1:0] cfg_index = mffa_pkg::CFG_BASE;
    logic [31:0]                    cfg_data = '0;

    multicore_first_fit_arena_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Requests waiting to be sent, and the responses the allocator model predicts.
    mffa_pkg::req_t pending_reqs[$];
    mffa_pkg::rsp_t expected_rsps[$];
    int   error_count = 0;
    int   reqs_sent = 0;
    int   rsps_checked = 0;

    // Shadow copy of the allocator: configuration, allocation table and seal counts.
    logic [31:0] sh_base = '0;
    logic [31:0] sh_limit = '0;
    logic [3:0]  sh_cols = 4'd8;
    logic [3:0]  sh_rows = 4'd8;
    logic        sh_valid [mffa_pkg::MAX_ENTRIES];
    logic [31:0] sh_id    [mffa_pkg::MAX_ENTRIES];
    logic [31:0] sh_begin [mffa_pkg::MAX_ENTRIES];
    logic [63:0] sh_end   [mffa_pkg::MAX_ENTRIES];
    logic [63:0] sh_cores [mffa_pkg::MAX_ENTRIES];
    logic [31:0] sh_next_id = 32'd1;
    logic [mffa_pkg::SEAL_BITS-1:0] sh_seals [mffa_pkg::MAX_CORES];

    initial
    begin
        for (int e = 0; e < mffa_pkg::MAX_ENTRIES; e++)
        begin
            sh_valid[e] = 1'b0;
        end
        for (int c = 0; c < mffa_pkg::MAX_CORES; c++)
        begin
            sh_seals[c] = '0;
        end
    end

    // Cores that exist in the present grid, as a bit mask.
    function automatic logic [63:0] grid_cores();
        int n;
        n = sh_cols * sh_rows;
        if (n >= mffa_pkg::MAX_CORES)
        begin
            return '1;
        end
        return (64'd1 << n) - 64'd1;
    endfunction

    function automatic logic [63:0] round_up(logic [63:0] x, logic [63:0] a);
        return (x + a - 64'd1) & ~(a - 64'd1);
    endfunction

    // First-fit placement; updates the shadow table on success.
    function automatic mffa_pkg::status_t place_region(mffa_pkg::req_t r,
                                                       output logic [31:0] gid,
                                                       output logic [31:0] addr);
        logic [63:0] a;
        logic [63:0] lim;
        logic [63:0] sz;
        logic [63:0] cand;
        logic [63:0] nxt;
        logic [63:0] t;
        int best;
        int slot;
        gid = '0;
        addr = '0;
        a = 64'd1 << r.align_log2;
        lim = {32'd0, sh_limit};
        sz = {32'd0, r.request_size};
        if (r.core_mask == '0 || sz == '0)
        begin
            return mffa_pkg::ST_BADREQ;
        end
        if ((r.core_mask & ~grid_cores()) != '0)
        begin
            return mffa_pkg::ST_BADREQ;
        end
        for (int c = 0; c < mffa_pkg::MAX_CORES; c++)
        begin
            if (r.core_mask[c] && sh_seals[c] != '0)
            begin
                return mffa_pkg::ST_SEALED;
            end
        end
        cand = round_up({32'd0, sh_base}, a);
        while (1)
        begin
            if (cand > lim || sz > lim - cand)
            begin
                return mffa_pkg::ST_NOSPACE;
            end
            nxt = cand;
            for (int c = 0; c < mffa_pkg::MAX_CORES; c++)
            begin
                if (!r.core_mask[c])
                begin
                    continue;
                end
                best = -1;
                for (int e = 0; e < mffa_pkg::MAX_ENTRIES; e++)
                begin
                    if (sh_valid[e] && sh_cores[e][c] && cand < sh_end[e]
                        && cand + sz > {32'd0, sh_begin[e]})
                    begin
                        if (best < 0 || sh_begin[e] < sh_begin[best])
                        begin
                            best = e;
                        end
                    end
                end
                if (best >= 0)
                begin
                    t = round_up(sh_end[best], a);
                    if (t > nxt)
                    begin
                        nxt = t;
                    end
                end
            end
            if (nxt == cand)
            begin
                break;
            end
            cand = nxt;
        end
        if (sh_next_id == '0)
        begin
            return mffa_pkg::ST_IDEXH;
        end
        slot = -1;
        for (int e = 0; e < mffa_pkg::MAX_ENTRIES; e++)
        begin
            if (!sh_valid[e])
            begin
                slot = e;
                break;
            end
        end
        if (slot < 0)
        begin
            return mffa_pkg::ST_FULL;
        end
        sh_valid[slot] = 1'b1;
        sh_id[slot] = sh_next_id;
        sh_begin[slot] = cand[31:0];
        sh_end[slot] = cand + sz;
        sh_cores[slot] = r.core_mask;
        gid = sh_next_id;
        addr = cand[31:0];
        sh_next_id = sh_next_id + 32'd1;
        return mffa_pkg::ST_OK;
    endfunction

    // Works out the response to one accepted request and queues it.
    function automatic void predict_response(mffa_pkg::req_t r);
        mffa_pkg::rsp_t    rsp;
        mffa_pkg::status_t st;
        logic [31:0] gid;
        logic [31:0] addr;
        logic [63:0] hw;
        st = mffa_pkg::ST_OK;
        gid = '0;
        addr = '0;
        case (r.req_type) inside
            mffa_pkg::REQ_ALLOC:
            begin
                st = place_region(r, gid, addr);
            end
            mffa_pkg::REQ_DEALLOC:
            begin
                if (r.free_id != '0)
                begin
                    st = mffa_pkg::ST_UNKNOWN;
                    for (int e = 0; e < mffa_pkg::MAX_ENTRIES; e++)
                    begin
                        if (sh_valid[e] && sh_id[e] == r.free_id)
                        begin
                            sh_valid[e] = 1'b0;
                            st = mffa_pkg::ST_OK;
                            break;
                        end
                    end
                end
            end
            mffa_pkg::REQ_HWM:
            begin
                hw = {32'd0, sh_base};
                for (int e = 0; e < mffa_pkg::MAX_ENTRIES; e++)
                begin
                    if (sh_valid[e] && (sh_cores[e] & r.core_mask) != '0 && sh_end[e] > hw)
                    begin
                        hw = sh_end[e];
                    end
                end
                addr = hw[31:0];
            end
            mffa_pkg::REQ_SEAL, mffa_pkg::REQ_UNSEAL:
            begin
                if ((r.core_mask & ~grid_cores()) != '0)
                begin
                    st = mffa_pkg::ST_BADREQ;
                end
                else
                begin
                    for (int c = 0; c < mffa_pkg::MAX_CORES; c++)
                    begin
                        if (r.core_mask[c] && r.req_type == mffa_pkg::REQ_SEAL
                            && sh_seals[c] == '1)
                        begin
                            st = mffa_pkg::ST_SEALOVF;
                        end
                        if (r.core_mask[c] && r.req_type == mffa_pkg::REQ_UNSEAL
                            && sh_seals[c] == '0)
                        begin
                            st = mffa_pkg::ST_NOTSEALED;
                        end
                    end
                    if (st == mffa_pkg::ST_OK)
                    begin
                        for (int c = 0; c < mffa_pkg::MAX_CORES; c++)
                        begin
                            if (r.core_mask[c])
                            begin
                                sh_seals[c] = (r.req_type == mffa_pkg::REQ_SEAL)
                                              ? sh_seals[c] + 1'b1 : sh_seals[c] - 1'b1;
                            end
                        end
                    end
                end
            end
            default:
            begin
                st = mffa_pkg::ST_BADREQ;
            end
        endcase
        rsp.status = st;
        rsp.granted_id = gid;
        rsp.result_address = addr;
        expected_rsps.push_back(rsp);
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Sender: bursts of back-to-back words separated by random idle gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (req_valid)
            begin
                predict_response(req_word);
                reqs_sent++;
            end
            if (gap_left > 0)
            begin
                gap_left--;
                req_valid <= 1'b0;
            end
            else if (pending_reqs.size() > 0)
            begin
                req_word <= pending_reqs.pop_front();
                req_valid <= 1'b1;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40) : 0;
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: the stall pattern changes mode now and then, from none to heavy.
    int stall_mode = 0;
    int mode_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsps_checked++;
                if (expected_rsps.size() == 0)
                begin
                    report_mismatch("unexpected word status", rsp_word.status, '0);
                end
                else
                begin
                    if (rsp_word.status != expected_rsps[0].status)
                    begin
                        report_mismatch("status", rsp_word.status, expected_rsps[0].status);
                    end
                    if (rsp_word.granted_id != expected_rsps[0].granted_id)
                    begin
                        report_mismatch("granted_id", rsp_word.granted_id,
                                        expected_rsps[0].granted_id);
                    end
                    if (rsp_word.result_address != expected_rsps[0].result_address)
                    begin
                        report_mismatch("result_address", rsp_word.result_address,
                                        expected_rsps[0].result_address);
                    end
                    void'(expected_rsps.pop_front());
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (stall_mode)
                0: rsp_stall <= 1'b0;
                1: rsp_stall <= $urandom_range(0, 1);
                default: rsp_stall <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Register writes happen only while nothing is in flight.
    task automatic write_reg(logic [mffa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mffa_pkg::CFG_BASE:  sh_base = val;
            mffa_pkg::CFG_LIMIT: sh_limit = val;
            mffa_pkg::CFG_COLS:  sh_cols = val[3:0];
            default:             sh_rows = val[3:0];
        endcase
    endtask

    task automatic set_arena(logic [31:0] b, logic [31:0] l, int cols, int rows);
        write_reg(mffa_pkg::CFG_BASE, b);
        write_reg(mffa_pkg::CFG_LIMIT, l);
        write_reg(mffa_pkg::CFG_COLS, cols);
        write_reg(mffa_pkg::CFG_ROWS, rows);
    endtask

    task automatic drain();
        while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
    endtask

    task automatic push_req(logic [2:0] kind, logic [63:0] mask, logic [31:0] sz,
                            logic [4:0] lg, logic [31:0] fid);
        mffa_pkg::req_t r;
        r.req_type = kind;
        r.core_mask = mask;
        r.request_size = sz;
        r.align_log2 = lg;
        r.free_id = fid;
        pending_reqs.push_back(r);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // A core mask, usually a single present core, sometimes a random subset of the grid or a fully random mask.
    function automatic logic [63:0] pick_mask();
        int n;
        n = sh_cols * sh_rows;
        if (n > mffa_pkg::MAX_CORES)
        begin
            n = mffa_pkg::MAX_CORES;
        end
        case ($urandom_range(0, 19)) inside
            0:         return rand64();
            [1:3]:     return rand64() & grid_cores();
            default:   return 64'd1 << $urandom_range(0, n - 1);
        endcase
    endfunction

    // One batch of random requests; batches keep free ids close to the live set.
    task automatic random_batch(int count, bit wide_sizes);
        int          pick;
        logic [31:0] sz;
        logic [31:0] fid;
        logic [4:0]  lg;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            sz = wide_sizes && $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 300);
            if ($urandom_range(0, 40) == 0)
            begin
                sz = '0;
            end
            lg = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
            if (pick < 50)
            begin
                push_req(mffa_pkg::REQ_ALLOC, pick_mask(), sz, lg, $urandom);
            end
            else if (pick < 75)
            begin
                case ($urandom_range(0, 9))
                    0:       fid = '0;
                    1:       fid = $urandom;
                    default: fid = $urandom_range(sh_next_id > 20 ? sh_next_id - 20 : 1,
                                                  sh_next_id + 2);
                endcase
                push_req(mffa_pkg::REQ_DEALLOC, rand64(), $urandom, $urandom, fid);
            end
            else if (pick < 84)
            begin
                push_req(mffa_pkg::REQ_HWM, pick_mask(), $urandom, $urandom, $urandom);
            end
            else if (pick < 90)
            begin
                push_req(mffa_pkg::REQ_SEAL, pick_mask(), $urandom, $urandom, $urandom);
            end
            else if (pick < 98)
            begin
                push_req(mffa_pkg::REQ_UNSEAL, pick_mask(), $urandom, $urandom, $urandom);
            end
            else
            begin
                push_req($urandom_range(5, 7), rand64(), $urandom, $urandom, $urandom);
            end
        end
        while (pending_reqs.size() > 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic random_phase(int batches, bit wide_sizes);
        for (int b = 0; b < batches; b++)
        begin
            random_batch($urandom_range(16, 36), wide_sizes);
        end
        drain();
    endtask

    initial
    begin
        int core;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed checks on the reset configuration: an empty arena and a full 8x8 grid.
        push_req(mffa_pkg::REQ_ALLOC, 64'd1, 32'd1, 5'd0, '0);
        push_req(mffa_pkg::REQ_ALLOC, '0, 32'd16, 5'd0, '0);
        push_req(mffa_pkg::REQ_ALLOC, 64'd1, '0, 5'd0, '0);
        push_req(mffa_pkg::REQ_DEALLOC, '0, '0, '0, '0);
        push_req(mffa_pkg::REQ_DEALLOC, '0, '0, '0, 32'd5);
        push_req(mffa_pkg::REQ_HWM, '0, '0, '0, '0);
        push_req(mffa_pkg::REQ_SEAL, 64'h8000_0000_0000_0000, '0, '0, '0);
        push_req(mffa_pkg::REQ_UNSEAL, 64'h8000_0000_0000_0000, '0, '0, '0);
        push_req(mffa_pkg::REQ_UNSEAL, 64'h8000_0000_0000_0000, '0, '0, '0);
        push_req(mffa_pkg::REQ_SEAL, '0, '0, '0, '0);
        push_req(3'd5, '0, '0, '0, '0);
        push_req(3'd7, '1, '1, '1, '1);
        drain();

        // A small 4x2 grid: placement, alignment, grid bounds, sealed cores.
        set_arena(32'h100, 32'h2000, 4, 2);
        push_req(mffa_pkg::REQ_ALLOC, 64'h1, 32'd16, 5'd0, '0);
        push_req(mffa_pkg::REQ_ALLOC, 64'h3, 32'd16, 5'd6, '0);
        push_req(mffa_pkg::REQ_ALLOC, 64'h100, 32'd16, 5'd0, '0);
        push_req(mffa_pkg::REQ_SEAL, 64'h2, '0, '0, '0);
        push_req(mffa_pkg::REQ_ALLOC, 64'h3, 32'd8, 5'd0, '0);
        push_req(mffa_pkg::REQ_UNSEAL, 64'h2, '0, '0, '0);
        push_req(mffa_pkg::REQ_SEAL, 64'h200, '0, '0, '0);
        push_req(mffa_pkg::REQ_ALLOC, 64'h80, 32'hFFFF_FFFF, 5'd31, '0);
        push_req(mffa_pkg::REQ_HWM, 64'h3, '0, '0, '0);
        push_req(mffa_pkg::REQ_DEALLOC, '0, '0, '0, 32'd1);
        push_req(mffa_pkg::REQ_ALLOC, 64'h1, 32'd4, 5'd2, '0);
        drain();

        // Count saturation on one core: seal up to the ceiling, one more, then unwind.
        core = $urandom_range(0, 7);
        for (int i = 0; i < (1 << mffa_pkg::SEAL_BITS); i++)
        begin
            push_req(mffa_pkg::REQ_SEAL, 64'd1 << core, '0, '0, '0);
        end
        push_req(mffa_pkg::REQ_ALLOC, 64'd1 << core, 32'd4, 5'd0, '0);
        for (int i = 0; i < (1 << mffa_pkg::SEAL_BITS); i++)
        begin
            push_req(mffa_pkg::REQ_UNSEAL, 64'd1 << core, '0, '0, '0);
        end
        drain();

        // Random traffic across several arenas and grid shapes, extremes included.
        random_phase(5, 1'b0);
        set_arena(32'h0, 32'hFFFF_FFFF, 8, 8);
        random_phase(5, 1'b1);
        set_arena(32'hFFFF_F000, 32'hFFFF_FFFF, 1, 1);
        random_phase(3, 1'b1);
        set_arena(32'h40, 32'h800, 3, 5);
        random_phase(5, 1'b0);
        set_arena(32'h1000, 32'h10, 8, 1);
        random_phase(2, 1'b0);
        set_arena(32'h0, 32'h400, 15, 15);
        random_phase(3, 1'b0);

        $display("Sent %0d requests over seven arena settings, checked %0d responses.",
                 reqs_sent, rsps_checked);
        $display("Covered allocate, free, high-water, seal and unseal with random stalls.");
        if (error_count == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #8000000;
        $display("Timeout with %0d responses still expected.", expected_rsps.size());
        $display("testbench: done, errors");
        $finish;
    end

endmodule

### sim.f
rtl/mffa_pkg.sv
rtl/mffa_datapath.sv
rtl/mffa_ctrl.sv
rtl/multicore_first_fit_arena_allocator.sv
tb/testbench.sv
